### hw/rtl/lrust_pkg.sv
// Package with the shared types and constants of the LRU session slot table.
`timescale 1ns / 1ps
package lrust_pkg;

    localparam int KEY_W      = 64;
    localparam int TURN_W     = 32;
    localparam int STAMP_W    = 64;
    localparam int SLOT_IDX_W = 12;
    localparam int OUT_IDX_W  = 8;

    localparam logic [TURN_W-1:0] TURN_MAX = '1;

    // Search token that walks along the cell chain.
    typedef struct packed {
        logic                  vld;
        logic [KEY_W-1:0]      key;
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic [TURN_W-1:0]     hit_turns;
        logic                  free;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic                  old;
        logic [SLOT_IDX_W-1:0] old_idx;
        logic [STAMP_W-1:0]    old_stamp;
    } t_tok;

    // Write-back broadcast to every cell.
    typedef struct packed {
        logic                  vld;
        logic                  new_entry;
        logic [SLOT_IDX_W-1:0] idx;
        logic [KEY_W-1:0]      key;
        logic [TURN_W-1:0]     turns;
        logic [STAMP_W-1:0]    stamp;
    } t_upd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

endpackage

### hw/rtl/lrust_cell.sv
// One slot of the table, which also updates the search token passing through it.
`timescale 1ns / 1ps
module lrust_cell #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lrust_pkg::t_tok i_tok,
    input  lrust_pkg::t_upd i_upd,
    output lrust_pkg::t_tok o_tok
);
    import lrust_pkg::*;

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [TURN_W-1:0]  r_turns;
    logic [STAMP_W-1:0] r_stamp;
    t_tok               r_tok;
    t_tok               n_tok;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_valid && r_key == i_tok.key) begin
            n_tok.hit       = 1'b1;
            n_tok.hit_idx   = MY_IDX;
            n_tok.hit_turns = r_turns;
        end
        if (!i_tok.free && !r_valid) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = MY_IDX;
        end
        // Strict compare keeps the lowest slot among equal stamps.
        if (r_valid && (!i_tok.old || r_stamp < i_tok.old_stamp)) begin
            n_tok.old       = 1'b1;
            n_tok.old_idx   = MY_IDX;
            n_tok.old_stamp = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
            if (i_upd.vld && i_upd.idx == MY_IDX) begin
                r_valid <= 1'b1;
            end
        end
        r_tok.key       <= n_tok.key;
        r_tok.hit       <= n_tok.hit;
        r_tok.hit_idx   <= n_tok.hit_idx;
        r_tok.hit_turns <= n_tok.hit_turns;
        r_tok.free      <= n_tok.free;
        r_tok.free_idx  <= n_tok.free_idx;
        r_tok.old       <= n_tok.old;
        r_tok.old_idx   <= n_tok.old_idx;
        r_tok.old_stamp <= n_tok.old_stamp;
        if (i_upd.vld && i_upd.idx == MY_IDX) begin
            if (i_upd.new_entry) begin
                r_key <= i_upd.key;
            end
            r_turns <= i_upd.turns;
            r_stamp <= i_upd.stamp;
        end
    end

    assign o_tok = r_tok;

endmodule

### hw/rtl/lru_session_slot_table.sv
// Top level of the LRU session slot table: cell chain, sequencer and result register.
//
//  channel | dir | handshake           | payload
//  s       | in  | i_s_tvalid/o_s_tready | tdata[63:0] session_key
//  m       | out | o_m_tvalid/i_m_tready | tdata[7:0] slot_index, [39:8] turn_count;
//          |     |                       | tuser[0] hit, [1] evicted
//
// For each item the search token walks the chain of NUM_SLOTS cells one
// cell a cycle, the search outcome is registered, and the write-back step
// writes the chosen slot back and loads the result register.
// One item is handled at a time; a waiting result holds the write-back step.
// Reset clears all valid bits and the use clock at once; no clearing pass.
`timescale 1ns / 1ps
module lru_session_slot_table #(
    parameter int NUM_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] session_key
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] slot_index, [39:8] turn_count
    output logic [1:0]  o_m_tuser    // [0] hit, [1] evicted
);
    import lrust_pkg::*;

    t_tok               w_tok [NUM_SLOTS+1];
    t_upd               w_upd;
    t_state             r_state;
    t_state             n_state;
    logic [STAMP_W-1:0] r_clock;
    t_tok               r_res;
    logic               r_out_vld;
    logic [39:0]        r_out_data;
    logic [1:0]         r_out_user;
    logic               w_out_free;
    logic               w_emit;
    logic               w_acc;
    logic [SLOT_IDX_W-1:0] w_sel;
    logic [TURN_W-1:0]  w_turns;
    logic               w_evict;

    assign w_out_free = !r_out_vld || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].vld       = w_acc;
        w_tok[0].key       = i_s_tdata;
        w_tok[0].old_stamp = '1;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        lrust_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_upd   (w_upd),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        if (r_res.hit) begin
            w_sel   = r_res.hit_idx;
            w_turns = (r_res.hit_turns == TURN_MAX) ? TURN_MAX
                                                    : r_res.hit_turns + TURN_W'(1);
        end else if (r_res.free) begin
            w_sel   = r_res.free_idx;
            w_turns = TURN_W'(1);
        end else begin
            w_sel   = r_res.old_idx;
            w_turns = TURN_W'(1);
        end
        w_evict = !r_res.hit && !r_res.free;
    end

    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[NUM_SLOTS].vld) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_upd.vld       = w_emit;
        w_upd.new_entry = !r_res.hit;
        w_upd.idx       = w_sel;
        w_upd.key       = r_res.key;
        w_upd.turns     = w_turns;
        w_upd.stamp     = r_clock + STAMP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clock   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_clock   <= r_clock + STAMP_W'(1);
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (r_state == S_SCAN && w_tok[NUM_SLOTS].vld) begin
            r_res <= w_tok[NUM_SLOTS];
        end
        if (w_emit) begin
            r_out_data <= {w_turns, w_sel[OUT_IDX_W-1:0]};
            r_out_user <= {w_evict, r_res.hit};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

### hw/rtl/lrust_checker.sv
// Port-level checker for the LRU session slot table, bound to the top level.
`timescale 1ns / 1ps
module lrust_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[39:8] != 32'd0)
        else $error("turn count of zero");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("hit and evicted both set");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while a search is in flight");

endmodule

bind lru_session_slot_table lrust_checker u_lrust_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
